@@ rtl/hsvrgb_pkg.sv @@
// Constants for the HSV to RGB converter: reciprocal multipliers and sector codes.
// No dependencies.
package hsvrgb_pkg;

  // h / 60 as (h * SECT_RECIP) >> SECT_SHIFT, exact for any 9-bit hue
  localparam logic [10:0] SECT_RECIP = 11'd1093;
  localparam int unsigned SECT_SHIFT = 16;

  // floor(h * 1000 / 60) as (h * FRAC_RECIP) >> FRAC_SHIFT, exact for any 9-bit hue
  localparam logic [20:0] FRAC_RECIP = 21'd1092300;
  localparam int unsigned FRAC_SHIFT = 16;

  // x / 255 for any 16-bit x
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int unsigned DIV255_SHIFT = 23;

  // x / 255000 for any 26-bit x
  localparam logic [27:0] DIV255K_RECIP = 28'd137977930;
  localparam int unsigned DIV255K_SHIFT = 45;

  // x / 1000 for any 18-bit x
  localparam logic [18:0] DIV1K_RECIP = 19'd268436;
  localparam int unsigned DIV1K_SHIFT = 28;

  localparam logic [9:0] FRAC_ONE = 10'd1000;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // colour wheel sectors
  localparam logic [3:0] SECT_RED_YEL = 4'd0;
  localparam logic [3:0] SECT_YEL_GRN = 4'd1;
  localparam logic [3:0] SECT_GRN_CYN = 4'd2;
  localparam logic [3:0] SECT_CYN_BLU = 4'd3;
  localparam logic [3:0] SECT_BLU_MAG = 4'd4;
  localparam logic [3:0] SECT_MAG_RED = 4'd5;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB converter, seven-stage pipeline.
// Depends on hsvrgb_pkg.
//
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+-------------------------
//  colour in| hue_i, saturation_i, level_i          | start_i while !busy_o
//  colour out| red_o, green_o, blue_o               | done_o, one cycle each
//
// One colour per clock; each result passes through stages 1 to 6 and the output word, then done_o rises.
// The reciprocal multipliers feed stages 2, 3 and 5 and the output word.
// busy_o is never raised: the receiver cannot stall, so nothing backs up.
// Reset clears the valid bits only; data registers are not reset.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
#(
  parameter int unsigned HUE_LIMIT = 360
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [8:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] level_i,
  output logic       done_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic [6:0] vld_q;

  // stage 1: hue, forced to zero at or above HUE_LIMIT
  logic [8:0] h1_q;
  logic [7:0] s1_q, v1_q;

  // stage 2: sector, scaled hue, level * saturation
  logic [3:0]  sec2_q;
  logic [13:0] hf2_q;
  logic [15:0] vs2_q;
  logic [7:0]  s2_q, v2_q;

  // stage 3: fraction, p
  logic [3:0]  sec3_q;
  logic [9:0]  frac3_q;
  logic [15:0] vs3_q;
  logic [7:0]  s3_q, v3_q, p3_q;

  // stage 4: products for q and t
  logic [3:0]  sec4_q;
  logic [25:0] y4_q;
  logic [17:0] x4_q;
  logic [7:0]  s4_q, v4_q, p4_q;

  // stage 5: q and the t weight
  logic [3:0] sec5_q;
  logic [7:0] s5_q, v5_q, p5_q, q5_q, w5_q;

  // stage 6: level * weight
  logic [3:0]  sec6_q;
  logic [15:0] vw6_q;
  logic [7:0]  s6_q, v6_q, p6_q, q6_q;

  // output word
  logic [7:0] red_q, green_q, blue_q;

  logic [8:0]  h1_d;
  logic [19:0] sec_prod;
  logic [29:0] hf_prod;
  logic [13:0] sec_k;
  logic [13:0] frac_d;
  logic [31:0] p_prod;
  logic [9:0]  frac_inv;
  logic [53:0] q_prod;
  logic [36:0] t_prod;
  logic [7:0]  q_div, t_w_div;
  logic [31:0] vw_prod;
  logic [7:0]  t7;
  logic [7:0]  red_d, green_d, blue_d;

  assign busy_o = 1'b0;

  assign h1_d = (hue_i >= 9'(HUE_LIMIT)) ? 9'd0 : hue_i;

  assign sec_prod = 20'(h1_q) * 20'(SECT_RECIP);
  assign hf_prod  = 30'(h1_q) * 30'(FRAC_RECIP);

  assign sec_k  = 14'(sec2_q) * 14'(FRAC_ONE);
  assign frac_d = hf2_q - sec_k;
  assign p_prod = 32'(vs2_q) * 32'(DIV255_RECIP);

  assign frac_inv = FRAC_ONE - frac3_q;

  assign q_prod  = 54'(y4_q) * 54'(DIV255K_RECIP);
  assign t_prod  = 37'(x4_q) * 37'(DIV1K_RECIP);
  assign q_div   = q_prod[DIV255K_SHIFT +: 8];
  assign t_w_div = t_prod[DIV1K_SHIFT +: 8];

  assign vw_prod = 32'(vw6_q) * 32'(DIV255_RECIP);
  assign t7      = vw_prod[DIV255_SHIFT +: 8];

  always_comb begin
    if (s6_q == 8'd0) begin
      red_d   = v6_q;
      green_d = v6_q;
      blue_d  = v6_q;
    end else begin
      case (sec6_q)
        SECT_RED_YEL: begin red_d = v6_q; green_d = t7;   blue_d = p6_q; end
        SECT_YEL_GRN: begin red_d = q6_q; green_d = v6_q; blue_d = p6_q; end
        SECT_GRN_CYN: begin red_d = p6_q; green_d = v6_q; blue_d = t7;   end
        SECT_CYN_BLU: begin red_d = p6_q; green_d = q6_q; blue_d = v6_q; end
        SECT_BLU_MAG: begin red_d = t7;   green_d = p6_q; blue_d = v6_q; end
        SECT_MAG_RED: begin red_d = v6_q; green_d = p6_q; blue_d = q6_q; end
        default: begin
          red_d   = 8'd0;
          green_d = 8'd0;
          blue_d  = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
    s1_q <= saturation_i;
    v1_q <= level_i;

    sec2_q <= sec_prod[SECT_SHIFT +: 4];
    hf2_q  <= hf_prod[FRAC_SHIFT +: 14];
    vs2_q  <= 16'(v1_q) * 16'(s1_q);
    s2_q   <= s1_q;
    v2_q   <= v1_q;

    sec3_q  <= sec2_q;
    frac3_q <= frac_d[9:0];
    vs3_q   <= vs2_q;
    s3_q    <= s2_q;
    v3_q    <= v2_q;
    p3_q    <= v2_q - p_prod[DIV255_SHIFT +: 8];

    sec4_q <= sec3_q;
    y4_q   <= 26'(vs3_q) * 26'(frac3_q);
    x4_q   <= 18'(s3_q) * 18'(frac_inv);
    s4_q   <= s3_q;
    v4_q   <= v3_q;
    p4_q   <= p3_q;

    sec5_q <= sec4_q;
    s5_q   <= s4_q;
    v5_q   <= v4_q;
    p5_q   <= p4_q;
    q5_q   <= v4_q - q_div;
    w5_q   <= CHAN_MAX - t_w_div;

    sec6_q <= sec5_q;
    vw6_q  <= 16'(v5_q) * 16'(w5_q);
    s6_q   <= s5_q;
    v6_q   <= v5_q;
    p6_q   <= p5_q;
    q6_q   <= q5_q;

    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = vld_q[6];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
